// File: rtl/emsa_pkg.sv
// ----------------------------------------------------------------------------
// emsa_pkg: shared types and constants
// Sizes, request codes, controller states and the command/status bundles
// that connect the element matvec controller and datapath.
// ----------------------------------------------------------------------------
package emsa_pkg;

  // store sizes
  localparam int NODES          = 4096;
  localparam int MAX_ELEM_NODES = 32;
  localparam int NODE_AW        = $clog2(NODES);
  localparam int SLOT_AW        = $clog2(MAX_ELEM_NODES);

  // field widths
  localparam int NODE_W = 12;
  localparam int SLOT_W = 5;
  localparam int VAL_W  = 32;
  localparam int NPE_W  = 6;
  localparam int FRAC_W = 16;

  localparam logic [NPE_W-1:0] NPE_RESET = NPE_W'(4);

  // request codes
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CONN  = 2'd1,
    REQ_STIFF = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_GATHER = 2'd1,
    ST_MUL    = 2'd2,
    ST_ACC    = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic node_wr;   // load u and f at the input node
    logic conn_wr;   // set connectivity slot
    logic conn_rd;   // look up row and column nodes
    logic f_rd;      // read f at the input node
    logic gather;    // read u[col node] and f[row node]
    logic mul;       // form the product
    logic acc;       // add, saturate, write back f
    logic out_fire;  // read result shows next cycle
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic slot_ok;
  } status_t;

endpackage

// File: rtl/emsa_ram.sv
// ----------------------------------------------------------------------------
// emsa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module emsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/emsa_ctrl.sv
// ----------------------------------------------------------------------------
// emsa_ctrl: request sequencer
// Accepts requests, completes load/connectivity/read in the accept cycle
// and walks a stiffness item through gather, multiply and accumulate.
// ----------------------------------------------------------------------------
module emsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  emsa_pkg::status_t status,
  output logic              busy,
  output emsa_pkg::cmd_t    cmd
);

  emsa_pkg::state_t state_r, state_nxt;
  logic             accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy   = (state_r != emsa_pkg::ST_IDLE);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      emsa_pkg::ST_IDLE: begin
        if (accept) begin
          case (status.req)
            emsa_pkg::REQ_LOAD: begin
              cmd.node_wr = 1'b1;
            end
            emsa_pkg::REQ_CONN: begin
              cmd.conn_wr = 1'b1;
            end
            emsa_pkg::REQ_STIFF: begin
              // out-of-use slots drop the item here
              if (status.slot_ok) begin
                cmd.conn_rd = 1'b1;
                state_nxt   = emsa_pkg::ST_GATHER;
              end
            end
            emsa_pkg::REQ_READ: begin
              cmd.f_rd     = 1'b1;
              cmd.out_fire = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      emsa_pkg::ST_GATHER: begin
        cmd.gather = 1'b1;
        state_nxt  = emsa_pkg::ST_MUL;
      end
      emsa_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = emsa_pkg::ST_ACC;
      end
      emsa_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = emsa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = emsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/emsa_dp.sv
// ----------------------------------------------------------------------------
// emsa_dp: node stores, connectivity and Q16.16 multiply-accumulate
// Holds u, f and connectivity memories, the element size register and
// the product/saturation path; acts on controller commands.
// ----------------------------------------------------------------------------
module emsa_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  emsa_pkg::cmd_t                         cmd,
  output emsa_pkg::status_t                      status,
  // configuration
  input  logic                                   cfg_we,
  input  logic        [emsa_pkg::NPE_W-1:0]      cfg_data,
  // request fields
  input  logic        [1:0]                      in_req_type,
  input  logic        [emsa_pkg::NODE_W-1:0]     in_node_index,
  input  logic        [emsa_pkg::SLOT_W-1:0]     in_row_slot,
  input  logic        [emsa_pkg::SLOT_W-1:0]     in_col_slot,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_value_u,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_value_f,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_coefficient,
  // result
  output logic                                   out_strobe,
  output logic signed [emsa_pkg::VAL_W-1:0]      out_node_f,
  output logic        [emsa_pkg::NODE_W-1:0]     out_node_echo
);

  localparam int NAW  = emsa_pkg::NODE_AW;
  localparam int SAW  = emsa_pkg::SLOT_AW;
  localparam int VW   = emsa_pkg::VAL_W;
  localparam int PW   = 2 * VW;
  localparam int SW   = PW - emsa_pkg::FRAC_W + 1;
  localparam int NPW  = emsa_pkg::NPE_W;

  // 32-bit signed limits, sign-extended to the sum width
  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic [NPW-1:0]                npe_r;
  logic signed [VW-1:0]          k_r;
  logic signed [PW-1:0]          prod_r;
  logic [NAW-1:0]                nr_r;
  logic                          out_strobe_r;
  logic [emsa_pkg::NODE_W-1:0]   echo_r;

  logic [emsa_pkg::NODE_W-1:0]   conn_row_q, conn_col_q;
  logic [VW-1:0]                 u_q, f_q;
  logic [NAW-1:0]                in_node;
  logic                          slot_in_range;

  logic signed [SW-1:0]          sum;
  logic signed [VW-1:0]          sat;
  logic                          f_we;
  logic [NAW-1:0]                f_wa, f_ra;
  logic [VW-1:0]                 f_wd;

  // node number reduced to the store
  assign in_node = in_node_index[NAW-1:0];

  // slot check against the element size
  assign slot_in_range = (NPW'(in_row_slot) < npe_r) && (NPW'(in_col_slot) < npe_r) &&
                         (NPW'(in_row_slot) < NPW'(emsa_pkg::MAX_ELEM_NODES)) &&
                         (NPW'(in_col_slot) < NPW'(emsa_pkg::MAX_ELEM_NODES));

  assign status.req     = emsa_pkg::req_t'(in_req_type);
  assign status.slot_ok = slot_in_range;

  // element size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npe_r <= emsa_pkg::NPE_RESET;
    end else if (cfg_we) begin
      npe_r <= cfg_data;
    end
  end

  // connectivity, two copies for row and column lookup
  emsa_ram #(.WIDTH(emsa_pkg::NODE_W), .DEPTH(emsa_pkg::MAX_ELEM_NODES)) u_conn_row (
    .clk     (clk),
    .wr_en   (cmd.conn_wr && (32'(in_row_slot) < emsa_pkg::MAX_ELEM_NODES)),
    .wr_addr (in_row_slot[SAW-1:0]),
    .wr_data (emsa_pkg::NODE_W'(in_node)),
    .rd_en   (cmd.conn_rd),
    .rd_addr (in_row_slot[SAW-1:0]),
    .rd_data (conn_row_q)
  );

  emsa_ram #(.WIDTH(emsa_pkg::NODE_W), .DEPTH(emsa_pkg::MAX_ELEM_NODES)) u_conn_col (
    .clk     (clk),
    .wr_en   (cmd.conn_wr && (32'(in_row_slot) < emsa_pkg::MAX_ELEM_NODES)),
    .wr_addr (in_row_slot[SAW-1:0]),
    .wr_data (emsa_pkg::NODE_W'(in_node)),
    .rd_en   (cmd.conn_rd),
    .rd_addr (in_col_slot[SAW-1:0]),
    .rd_data (conn_col_q)
  );

  // nodal u store
  emsa_ram #(.WIDTH(VW), .DEPTH(emsa_pkg::NODES)) u_ustore (
    .clk     (clk),
    .wr_en   (cmd.node_wr),
    .wr_addr (in_node),
    .wr_data (in_value_u),
    .rd_en   (cmd.gather),
    .rd_addr (conn_col_q[NAW-1:0]),
    .rd_data (u_q)
  );

  // nodal f store: load or accumulate write, read or gather read
  assign f_we = cmd.node_wr || cmd.acc;
  assign f_wa = cmd.acc ? nr_r : in_node;
  assign f_wd = cmd.acc ? sat : in_value_f;
  assign f_ra = cmd.gather ? conn_row_q[NAW-1:0] : in_node;

  emsa_ram #(.WIDTH(VW), .DEPTH(emsa_pkg::NODES)) u_fstore (
    .clk     (clk),
    .wr_en   (f_we),
    .wr_addr (f_wa),
    .wr_data (f_wd),
    .rd_en   (cmd.f_rd || cmd.gather),
    .rd_addr (f_ra),
    .rd_data (f_q)
  );

  // coefficient, row node and product
  always_ff @(posedge clk) begin
    if (cmd.conn_rd) begin
      k_r <= in_coefficient;
    end
    if (cmd.gather) begin
      nr_r <= conn_row_q[NAW-1:0];
    end
    if (cmd.mul) begin
      prod_r <= PW'(k_r) * PW'($signed(u_q));
    end
  end

  // truncate to Q16.16 (floor), add f, clamp to 32 bits
  always_comb begin
    sum = SW'(prod_r >>> emsa_pkg::FRAC_W) + SW'($signed(f_q));
    if (sum > SUM_MAX) begin
      sat = {1'b0, {(VW-1){1'b1}}};
    end else if (sum < SUM_MIN) begin
      sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sat = sum[VW-1:0];
    end
  end

  // read result strobe and echo
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      echo_r <= in_node_index;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_node_f    = f_q;
  assign out_node_echo = echo_r;

endmodule

// File: rtl/element_matvec_scatter_accumulate_top.sv
// ----------------------------------------------------------------------------
// element_matvec_scatter_accumulate_top: matrix-free element matvec
// Scatters K[row][col] * u[conn[col]] into f[conn[row]] in signed Q16.16
// with saturation; loads nodes, sets connectivity and reads back f.
//
// Channel   Ports                               Transfer when
// request   start/busy, in_*                    start && !busy
// result    out_strobe, out_node_f/echo         out_strobe (one cycle)
// config    cfg_valid/cfg_ready, cfg_nodes_*    cfg_valid && cfg_ready
//
// Load, connectivity set, read and out-of-use stiffness items leave busy low.
// A stiffness item in use steps through connectivity lookup, then, with busy
// high, u/f memory read, 32x32 multiply, add/saturate/write back.
// A read result appears on the cycle after the request transfer.
// Reset sets nodes_per_element to 4; node stores start unwritten, no clear.
// The receiver cannot stall; results are strobed once.
// ----------------------------------------------------------------------------
module element_matvec_scatter_accumulate_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [1:0]                      in_req_type,
  input  logic        [emsa_pkg::NODE_W-1:0]     in_node_index,
  input  logic        [emsa_pkg::SLOT_W-1:0]     in_row_slot,
  input  logic        [emsa_pkg::SLOT_W-1:0]     in_col_slot,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_value_u,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_value_f,
  input  logic signed [emsa_pkg::VAL_W-1:0]      in_coefficient,
  // result
  output logic                                   out_strobe,
  output logic signed [emsa_pkg::VAL_W-1:0]      out_node_f,
  output logic        [emsa_pkg::NODE_W-1:0]     out_node_echo,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [emsa_pkg::NPE_W-1:0]      cfg_nodes_per_element
);

  emsa_pkg::cmd_t    cmd;
  emsa_pkg::status_t status;

  // config taken while the sequencer is idle
  assign cfg_ready = !busy;

  emsa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  emsa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_nodes_per_element),
    .in_req_type    (in_req_type),
    .in_node_index  (in_node_index),
    .in_row_slot    (in_row_slot),
    .in_col_slot    (in_col_slot),
    .in_value_u     (in_value_u),
    .in_value_f     (in_value_f),
    .in_coefficient (in_coefficient),
    .out_strobe     (out_strobe),
    .out_node_f     (out_node_f),
    .out_node_echo  (out_node_echo)
  );

endmodule
